/* design/mecanum_field_oriented_wheel_speeds_macros.svh */
// Assertion helpers shared by the mecanum wheel speed block.
// Every user has clk and rst_n in scope; checks are off while in reset.
`ifndef MECANUM_FIELD_ORIENTED_WHEEL_SPEEDS_MACROS_SVH
`define MECANUM_FIELD_ORIENTED_WHEEL_SPEEDS_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MFOWS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MFOWS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/mfows_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mfows_pkg;

    // sine table, one full turn
    localparam int SINE_TABLE_SIZE = 512;
    localparam int SINE_AW = $clog2(SINE_TABLE_SIZE);
    localparam int HALF_N = SINE_TABLE_SIZE / 2;
    localparam int HALF_AW = $clog2(HALF_N);
    localparam int ANG_W = 16;
    localparam int FRAC_W = 16;
    localparam int POS_W = ANG_W + SINE_AW;

    // field widths
    localparam int VX_W = 14;
    localparam int VY_W = 14;
    localparam int WZ_W = 16;
    localparam int OUT_W = 24;
    localparam int ARM_W = 11;
    localparam int INV_W = 13;
    localparam int Q15_W = 16;

    // APB
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // datapath widths
    localparam int DPROD_W = Q15_W + 1 + FRAC_W;
    localparam int RND_W = DPROD_W + 1;
    localparam int SC_W = Q15_W + 2;
    localparam int PROD_W = VX_W + Q15_W;
    localparam int ROT_W = PROD_W + 1;
    localparam int AW_W = ARM_W + WZ_W;
    localparam int TERM_W = ROT_W + 1;
    localparam int Q15_SHIFT = 15;
    localparam int SUM_W = 44;
    localparam int SPLIT = 21;
    localparam int HI_W = SUM_W - SPLIT;
    localparam int PLO_W = SPLIT + INV_W;
    localparam int PHI_W = HI_W + INV_W + 1;
    localparam int TOT_W = 58;
    localparam int OUT_SHIFT = 31;
    localparam int R_W = TOT_W - OUT_SHIFT;

    localparam int LATENCY = 9;
    localparam int N_WHEELS = 4;

    localparam logic [ANG_W-1:0] QUARTER_TURN = ANG_W'(16384);
    localparam logic signed [RND_W-1:0] ROUND_Q16 = RND_W'(32768);
    localparam logic signed [TOT_W-1:0] ROUND_Q31 = TOT_W'(64'sd1 <<< (OUT_SHIFT - 1));
    localparam logic signed [SUM_W-1:0] TERM_SCALE = SUM_W'(1000);
    localparam logic signed [R_W-1:0] SAT_HI = R_W'((2 ** (OUT_W - 1)) - 1);
    localparam logic signed [R_W-1:0] SAT_LO = R_W'(-(2 ** (OUT_W - 1)));
    localparam logic signed [OUT_W-1:0] OUT_MAX = OUT_W'((2 ** (OUT_W - 1)) - 1);
    localparam logic signed [OUT_W-1:0] OUT_MIN = OUT_W'(-(2 ** (OUT_W - 1)));

    localparam logic [ARM_W-1:0] FRONT_ARM_RST = ARM_W'(200);
    localparam logic [ARM_W-1:0] BACK_ARM_RST = ARM_W'(200);
    localparam logic [INV_W-1:0] INV_RADIUS_RST = INV_W'(862);

    localparam longint PI_Q30 = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = PI_Q30 / 2;
    localparam longint Q30_ONE = 64'sd1 <<< 30;

    // ceil(2^48 / ((2n)(2n+1))) for n = 1..10; exact quotients for
    // dividends below 2^33
    localparam int SERIES_SHIFT = 48;
    localparam longint SERIES_ONE = 64'sd1 <<< SERIES_SHIFT;
    localparam longint SERIES_RECIP [10] = '{
        (SERIES_ONE + 5) / 6,     (SERIES_ONE + 19) / 20,   (SERIES_ONE + 41) / 42,
        (SERIES_ONE + 71) / 72,   (SERIES_ONE + 109) / 110, (SERIES_ONE + 155) / 156,
        (SERIES_ONE + 209) / 210, (SERIES_ONE + 271) / 272, (SERIES_ONE + 341) / 342,
        (SERIES_ONE + 419) / 420
    };

    typedef enum logic [1:0] {
        REG_FRONT_ARM  = 2'd0,
        REG_BACK_ARM   = 2'd1,
        REG_INV_RADIUS = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [ARM_W-1:0] front_arm;
        logic [ARM_W-1:0] back_arm;
        logic [INV_W-1:0] inv_radius;
    } cfg_t;

    typedef struct packed {
        logic signed [VX_W-1:0] vx;
        logic signed [VY_W-1:0] vy;
        logic signed [WZ_W-1:0] wz;
    } cmd_t;

    typedef logic signed [Q15_W-1:0] sine_half_t [HALF_N];

    // exact Q30 Taylor series, folded into [-pi/2, pi/2]
    function automatic logic signed [Q15_W-1:0] sine_entry(input longint k);
        longint x;
        longint x2;
        longint term;
        longint sum;
        longint r;
        longint p;
        longint mag;
        longint q;
        logic [127:0] wide;
        x = (2 * PI_Q30 * k) / SINE_TABLE_SIZE;
        if (x > PI_Q30)
            x = x - 2 * PI_Q30;
        if (x > HALF_PI_Q30)
            x = PI_Q30 - x;
        else if (x < -HALF_PI_Q30)
            x = -PI_Q30 - x;
        x2 = (x * x) / Q30_ONE;
        term = x;
        sum = x;
        for (int n = 1; n <= 10; n++)
        begin
            // quotient truncated toward zero, then negated
            p = (term * x2) / Q30_ONE;
            mag = (p < 0) ? -p : p;
            wide = 128'(mag) * 128'(SERIES_RECIP[n - 1]);
            q = longint'(wide >> SERIES_SHIFT);
            term = (p < 0) ? q : -q;
            sum = sum + term;
        end
        r = (sum + ((sum >= 0) ? 64'sd16384 : -64'sd16384)) / 64'sd32768;
        if (r > 64'sd32767)
            r = 64'sd32767;
        if (r < -64'sd32767)
            r = -64'sd32767;
        return r[Q15_W-1:0];
    endfunction

    // even or odd entries, so idx and idx+1 always sit in different banks
    function automatic sine_half_t sine_half(input int odd);
        sine_half_t t;
        for (int i = 0; i < HALF_N; i++)
        begin
            t[i] = sine_entry(longint'(2 * i + odd));
        end
        return t;
    endfunction

    localparam sine_half_t SINE_EVEN = sine_half(0);
    localparam sine_half_t SINE_ODD = sine_half(1);

endpackage

`default_nettype wire

/* design/mfows_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "mecanum_field_oriented_wheel_speeds_macros.svh"

module mfows_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mfows_pkg::ADDR_W-1:0]  paddr,
    input  logic [mfows_pkg::DATA_W-1:0]  pwdata,
    output logic [mfows_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    output mfows_pkg::cfg_t               cfg
);
    import mfows_pkg::*;

    logic             wr_en;
    reg_idx_t         reg_idx;
    logic [ARM_W-1:0] front_arm_reg;
    logic [ARM_W-1:0] front_arm_next;
    logic [ARM_W-1:0] back_arm_reg;
    logic [ARM_W-1:0] back_arm_next;
    logic [INV_W-1:0] inv_radius_reg;
    logic [INV_W-1:0] inv_radius_next;

    assign pready = 1'b1;
    assign wr_en = psel & penable & pwrite & pready;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_comb
    begin
        front_arm_next = front_arm_reg;
        back_arm_next = back_arm_reg;
        inv_radius_next = inv_radius_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_FRONT_ARM:  front_arm_next = pwdata[ARM_W-1:0];
                REG_BACK_ARM:   back_arm_next = pwdata[ARM_W-1:0];
                REG_INV_RADIUS: inv_radius_next = pwdata[INV_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FRONT_ARM:  prdata = DATA_W'(front_arm_reg);
            REG_BACK_ARM:   prdata = DATA_W'(back_arm_reg);
            REG_INV_RADIUS: prdata = DATA_W'(inv_radius_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_arm_reg <= FRONT_ARM_RST;
            back_arm_reg <= BACK_ARM_RST;
            inv_radius_reg <= INV_RADIUS_RST;
        end
        else
        begin
            front_arm_reg <= front_arm_next;
            back_arm_reg <= back_arm_next;
            inv_radius_reg <= inv_radius_next;
        end
    end

    assign cfg.front_arm = front_arm_reg;
    assign cfg.back_arm = back_arm_reg;
    assign cfg.inv_radius = inv_radius_reg;

    `MFOWS_ASSERT_NEXT(a_front_arm_write, wr_en && (reg_idx == REG_FRONT_ARM), front_arm_reg == $past(pwdata[ARM_W-1:0]), "front arm register missed a write")

endmodule

`default_nettype wire

/* design/mfows_sincos.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "mecanum_field_oriented_wheel_speeds_macros.svh"

// Three stages: table read, slope times fraction, round and add.
// Lane 0 is the sine, lane 1 the cosine (angle plus a quarter turn).
module mfows_sincos (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  mfows_pkg::cmd_t                     in_cmd,
    input  logic [mfows_pkg::ANG_W-1:0]         yaw,
    output logic                                out_valid,
    output mfows_pkg::cmd_t                     out_cmd,
    output logic signed [mfows_pkg::Q15_W-1:0]  sin_q15,
    output logic signed [mfows_pkg::Q15_W-1:0]  cos_q15
);
    import mfows_pkg::*;

    logic [ANG_W-1:0]          ang [2];
    logic [POS_W-1:0]          pos [2];
    logic [SINE_AW-1:0]        idx [2];
    logic [HALF_AW-1:0]        half [2];
    logic [HALF_AW-1:0]        half_nxt [2];
    logic [HALF_AW-1:0]        even_addr [2];
    logic signed [Q15_W-1:0]   even_val [2];
    logic signed [Q15_W-1:0]   odd_val [2];
    logic signed [Q15_W-1:0]   a_next [2];
    logic signed [Q15_W-1:0]   b_next [2];
    logic [FRAC_W-1:0]         frac_next [2];
    logic signed [Q15_W-1:0]   a1_reg [2];
    logic signed [Q15_W-1:0]   b1_reg [2];
    logic [FRAC_W-1:0]         frac1_reg [2];
    logic signed [Q15_W:0]     diff [2];
    logic signed [DPROD_W-1:0] prod_next [2];
    logic signed [DPROD_W-1:0] prod2_reg [2];
    logic signed [Q15_W-1:0]   a2_reg [2];
    logic signed [RND_W-1:0]   rnd [2];
    logic signed [SC_W-1:0]    sc_full [2];
    logic signed [Q15_W-1:0]   sc_next [2];
    logic signed [Q15_W-1:0]   sc3_reg [2];
    cmd_t                      cmd1_reg;
    cmd_t                      cmd2_reg;
    cmd_t                      cmd3_reg;
    logic                      v1_reg;
    logic                      v2_reg;
    logic                      v3_reg;

    assign ang[0] = yaw;
    assign ang[1] = yaw + QUARTER_TURN;

    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            pos[j] = POS_W'(ang[j]) * POS_W'(SINE_TABLE_SIZE);
            idx[j] = pos[j][POS_W-1:FRAC_W];
            frac_next[j] = pos[j][FRAC_W-1:0];
            half[j] = idx[j][SINE_AW-1:1];
            half_nxt[j] = (half[j] == HALF_AW'(HALF_N - 1)) ? '0 : half[j] + 1'b1;
            // odd index: the next entry is the following even one
            even_addr[j] = idx[j][0] ? half_nxt[j] : half[j];
            even_val[j] = SINE_EVEN[even_addr[j]];
            odd_val[j] = SINE_ODD[half[j]];
            a_next[j] = idx[j][0] ? odd_val[j] : even_val[j];
            b_next[j] = idx[j][0] ? even_val[j] : odd_val[j];
        end
    end

    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            diff[j] = (Q15_W + 1)'(b1_reg[j]) - (Q15_W + 1)'(a1_reg[j]);
            prod_next[j] = DPROD_W'(diff[j]) * $signed(DPROD_W'(frac1_reg[j]));
        end
    end

    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            rnd[j] = RND_W'(prod2_reg[j]) + ROUND_Q16;
            sc_full[j] = SC_W'(a2_reg[j]) + $signed(rnd[j][RND_W-1:FRAC_W]);
            sc_next[j] = sc_full[j][Q15_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 2; j++)
        begin
            a1_reg[j] <= a_next[j];
            b1_reg[j] <= b_next[j];
            frac1_reg[j] <= frac_next[j];
            prod2_reg[j] <= prod_next[j];
            a2_reg[j] <= a1_reg[j];
            sc3_reg[j] <= sc_next[j];
        end
        cmd1_reg <= in_cmd;
        cmd2_reg <= cmd1_reg;
        cmd3_reg <= cmd2_reg;
    end

    assign out_valid = v3_reg;
    assign out_cmd = cmd3_reg;
    assign sin_q15 = sc3_reg[0];
    assign cos_q15 = sc3_reg[1];

    // interpolation never leaves the span of the two table entries
    `MFOWS_ASSERT_SAME(a_sincos_range, v3_reg, (sin_q15 >= -16'sd32767) && (cos_q15 >= -16'sd32767) && (sin_q15 != 16'sh8000) && (cos_q15 != 16'sh8000), "interpolated sine or cosine out of Q1.15 range")

endmodule

`default_nettype wire

/* design/mfows_rotate.sv */
`timescale 1ns / 1ps
`default_nettype none

// Two stages: the four rotation products and the arm times yaw-rate
// products, then the rotated vx and vy.
module mfows_rotate (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mfows_pkg::cfg_t                     cfg,
    input  logic                                in_valid,
    input  mfows_pkg::cmd_t                     in_cmd,
    input  logic signed [mfows_pkg::Q15_W-1:0]  sin_q15,
    input  logic signed [mfows_pkg::Q15_W-1:0]  cos_q15,
    output logic                                out_valid,
    output logic signed [mfows_pkg::ROT_W-1:0]  vx_rot,
    output logic signed [mfows_pkg::ROT_W-1:0]  vy_rot,
    output logic signed [mfows_pkg::AW_W-1:0]   aw_front,
    output logic signed [mfows_pkg::AW_W-1:0]   aw_back
);
    import mfows_pkg::*;

    logic signed [VX_W-1:0]   vx;
    logic signed [VY_W-1:0]   vy;
    logic signed [WZ_W-1:0]   wz;
    logic signed [PROD_W-1:0] pxc_next;
    logic signed [PROD_W-1:0] pys_next;
    logic signed [PROD_W-1:0] pyc_next;
    logic signed [PROD_W-1:0] pxs_next;
    logic signed [AW_W-1:0]   awf_next;
    logic signed [AW_W-1:0]   awb_next;
    logic signed [PROD_W-1:0] pxc_reg;
    logic signed [PROD_W-1:0] pys_reg;
    logic signed [PROD_W-1:0] pyc_reg;
    logic signed [PROD_W-1:0] pxs_reg;
    logic signed [AW_W-1:0]   awf1_reg;
    logic signed [AW_W-1:0]   awb1_reg;
    logic signed [ROT_W-1:0]  vxr_next;
    logic signed [ROT_W-1:0]  vyr_next;
    logic signed [ROT_W-1:0]  vxr_reg;
    logic signed [ROT_W-1:0]  vyr_reg;
    logic signed [AW_W-1:0]   awf2_reg;
    logic signed [AW_W-1:0]   awb2_reg;
    logic                     v1_reg;
    logic                     v2_reg;

    assign vx = $signed(in_cmd.vx);
    assign vy = $signed(in_cmd.vy);
    assign wz = $signed(in_cmd.wz);

    always_comb
    begin
        pxc_next = PROD_W'(vx) * PROD_W'(cos_q15);
        pys_next = PROD_W'(vy) * PROD_W'(sin_q15);
        pyc_next = PROD_W'(vy) * PROD_W'(cos_q15);
        pxs_next = PROD_W'(vx) * PROD_W'(sin_q15);
        awf_next = $signed(AW_W'(cfg.front_arm)) * AW_W'(wz);
        awb_next = $signed(AW_W'(cfg.back_arm)) * AW_W'(wz);
    end

    always_comb
    begin
        vxr_next = ROT_W'(pxc_reg) - ROT_W'(pys_reg);
        vyr_next = ROT_W'(pyc_reg) + ROT_W'(pxs_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pxc_reg <= pxc_next;
        pys_reg <= pys_next;
        pyc_reg <= pyc_next;
        pxs_reg <= pxs_next;
        awf1_reg <= awf_next;
        awb1_reg <= awb_next;
        vxr_reg <= vxr_next;
        vyr_reg <= vyr_next;
        awf2_reg <= awf1_reg;
        awb2_reg <= awb1_reg;
    end

    assign out_valid = v2_reg;
    assign vx_rot = vxr_reg;
    assign vy_rot = vyr_reg;
    assign aw_front = awf2_reg;
    assign aw_back = awb2_reg;

endmodule

`default_nettype wire

/* design/mfows_wheel.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "mecanum_field_oriented_wheel_speeds_macros.svh"

// Four stages per wheel: mecanum term, scaled sum, split product with
// the reciprocal radius, round and saturate.
// Wheel order: right front, left front, left back, right back.
module mfows_wheel (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mfows_pkg::cfg_t                     cfg,
    input  logic                                in_valid,
    input  logic signed [mfows_pkg::ROT_W-1:0]  vx_rot,
    input  logic signed [mfows_pkg::ROT_W-1:0]  vy_rot,
    input  logic signed [mfows_pkg::AW_W-1:0]   aw_front,
    input  logic signed [mfows_pkg::AW_W-1:0]   aw_back,
    output logic                                out_valid,
    output logic signed [mfows_pkg::OUT_W-1:0]  speed [mfows_pkg::N_WHEELS]
);
    import mfows_pkg::*;

    logic signed [TERM_W-1:0] vx_t;
    logic signed [TERM_W-1:0] vy_t;
    logic signed [TERM_W-1:0] term_next [N_WHEELS];
    logic signed [AW_W-1:0]   aw_next [N_WHEELS];
    logic signed [TERM_W-1:0] term_reg [N_WHEELS];
    logic signed [AW_W-1:0]   aw_reg [N_WHEELS];
    logic signed [SUM_W-1:0]  sum_next [N_WHEELS];
    logic signed [SUM_W-1:0]  sum_reg [N_WHEELS];
    logic [SPLIT-1:0]         sum_lo [N_WHEELS];
    logic signed [HI_W-1:0]   sum_hi [N_WHEELS];
    logic [PLO_W-1:0]         plo_next [N_WHEELS];
    logic signed [PHI_W-1:0]  phi_next [N_WHEELS];
    logic [PLO_W-1:0]         plo_reg [N_WHEELS];
    logic signed [PHI_W-1:0]  phi_reg [N_WHEELS];
    logic signed [TOT_W-1:0]  total [N_WHEELS];
    logic signed [R_W-1:0]    r [N_WHEELS];
    logic signed [OUT_W-1:0]  speed_next [N_WHEELS];
    logic signed [OUT_W-1:0]  speed_reg [N_WHEELS];
    logic                     v1_reg;
    logic                     v2_reg;
    logic                     v3_reg;
    logic                     done_reg;

    assign vx_t = TERM_W'(vx_rot);
    assign vy_t = TERM_W'(vy_rot);

    always_comb
    begin
        term_next[0] = -vx_t - vy_t;
        term_next[1] = vx_t - vy_t;
        term_next[2] = vx_t + vy_t;
        term_next[3] = -vx_t + vy_t;
        aw_next[0] = aw_front;
        aw_next[1] = aw_front;
        aw_next[2] = aw_back;
        aw_next[3] = aw_back;
    end

    always_comb
    begin
        for (int i = 0; i < N_WHEELS; i++)
        begin
            sum_next[i] = SUM_W'(term_reg[i]) * TERM_SCALE
                        + (SUM_W'(aw_reg[i]) <<< Q15_SHIFT);
        end
    end

    // sum times reciprocal radius as two narrow products
    always_comb
    begin
        for (int i = 0; i < N_WHEELS; i++)
        begin
            sum_lo[i] = sum_reg[i][SPLIT-1:0];
            sum_hi[i] = $signed(sum_reg[i][SUM_W-1:SPLIT]);
            plo_next[i] = PLO_W'(sum_lo[i]) * PLO_W'(cfg.inv_radius);
            phi_next[i] = PHI_W'(sum_hi[i]) * $signed(PHI_W'(cfg.inv_radius));
        end
    end

    always_comb
    begin
        for (int i = 0; i < N_WHEELS; i++)
        begin
            total[i] = (TOT_W'(phi_reg[i]) <<< SPLIT) + $signed(TOT_W'(plo_reg[i]))
                     + ROUND_Q31;
            r[i] = total[i][TOT_W-1:OUT_SHIFT];
            if (r[i] > SAT_HI)
                speed_next[i] = OUT_MAX;
            else if (r[i] < SAT_LO)
                speed_next[i] = OUT_MIN;
            else
                speed_next[i] = r[i][OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N_WHEELS; i++)
        begin
            term_reg[i] <= term_next[i];
            aw_reg[i] <= aw_next[i];
            sum_reg[i] <= sum_next[i];
            plo_reg[i] <= plo_next[i];
            phi_reg[i] <= phi_next[i];
            speed_reg[i] <= speed_next[i];
        end
    end

    assign out_valid = done_reg;
    assign speed = speed_reg;

    // a zero reciprocal radius must give standing wheels
    `MFOWS_ASSERT_SAME(a_zero_radius_stops, done_reg && ($past(cfg.inv_radius, 2) == '0), (speed_reg[0] == '0) && (speed_reg[1] == '0) && (speed_reg[2] == '0) && (speed_reg[3] == '0), "nonzero wheel speed with zero reciprocal radius")

endmodule

`default_nettype wire

/* design/mecanum_field_oriented_wheel_speeds.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "mecanum_field_oriented_wheel_speeds_macros.svh"

// Mecanum wheel speeds from a field-oriented chassis command. An item
// (vx_cmd, vy_cmd, wz_cmd, yaw_offset) is taken on any cycle with start
// high; busy never rises, so one item can enter every clock. The four
// wheel speeds pass through a pipeline of 3 stages sine/cosine lookup
// and interpolation, 2 stages rotation and 4 stages wheel mixing,
// radius scaling and saturation, and are shown for exactly one cycle
// with done high. The receiver cannot stall the block: it must take
// every result in the cycle it appears. Arm lengths and reciprocal
// radius sit in APB registers (front arm at 0x0, back arm at 0x4,
// reciprocal radius at 0x8) and are to be written only while no item
// is in flight.
module mecanum_field_oriented_wheel_speeds (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [mfows_pkg::VX_W-1:0]   vx_cmd,
    input  logic signed [mfows_pkg::VY_W-1:0]   vy_cmd,
    input  logic signed [mfows_pkg::WZ_W-1:0]   wz_cmd,
    input  logic [mfows_pkg::ANG_W-1:0]         yaw_offset,
    output logic                                done,
    output logic signed [mfows_pkg::OUT_W-1:0]  right_front_speed,
    output logic signed [mfows_pkg::OUT_W-1:0]  left_front_speed,
    output logic signed [mfows_pkg::OUT_W-1:0]  left_back_speed,
    output logic signed [mfows_pkg::OUT_W-1:0]  right_back_speed,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mfows_pkg::ADDR_W-1:0]        paddr,
    input  logic [mfows_pkg::DATA_W-1:0]        pwdata,
    output logic [mfows_pkg::DATA_W-1:0]        prdata,
    output logic                                pready
);
    import mfows_pkg::*;

    cfg_t                    cfg;
    cmd_t                    in_cmd;
    cmd_t                    sc_cmd;
    logic                    in_valid;
    logic                    sc_valid;
    logic signed [Q15_W-1:0] sin_q15;
    logic signed [Q15_W-1:0] cos_q15;
    logic                    rot_valid;
    logic signed [ROT_W-1:0] vx_rot;
    logic signed [ROT_W-1:0] vy_rot;
    logic signed [AW_W-1:0]  aw_front;
    logic signed [AW_W-1:0]  aw_back;
    logic signed [OUT_W-1:0] speed [N_WHEELS];

    assign busy = 1'b0;
    assign in_valid = start & ~busy;
    assign in_cmd.vx = vx_cmd;
    assign in_cmd.vy = vy_cmd;
    assign in_cmd.wz = wz_cmd;

    mfows_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mfows_sincos u_sincos (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_cmd    (in_cmd),
        .yaw       (yaw_offset),
        .out_valid (sc_valid),
        .out_cmd   (sc_cmd),
        .sin_q15   (sin_q15),
        .cos_q15   (cos_q15)
    );

    mfows_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (sc_valid),
        .in_cmd    (sc_cmd),
        .sin_q15   (sin_q15),
        .cos_q15   (cos_q15),
        .out_valid (rot_valid),
        .vx_rot    (vx_rot),
        .vy_rot    (vy_rot),
        .aw_front  (aw_front),
        .aw_back   (aw_back)
    );

    mfows_wheel u_wheel (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (rot_valid),
        .vx_rot    (vx_rot),
        .vy_rot    (vy_rot),
        .aw_front  (aw_front),
        .aw_back   (aw_back),
        .out_valid (done),
        .speed     (speed)
    );

    assign right_front_speed = speed[0];
    assign left_front_speed = speed[1];
    assign left_back_speed = speed[2];
    assign right_back_speed = speed[3];

    // every result traces back to an item taken a fixed latency earlier
    `MFOWS_ASSERT_SAME(a_done_latency, done, $past(start && !busy, LATENCY), "result without an item taken at the pipeline latency")

endmodule

`default_nettype wire

/* tb/sv/mecanum_field_oriented_wheel_speeds_tb.sv */
`timescale 1ns / 1ps

module mecanum_field_oriented_wheel_speeds_tb;

    import mfows_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic signed [VX_W-1:0] vx;
        logic signed [VY_W-1:0] vy;
        logic signed [WZ_W-1:0] wz;
        logic [ANG_W-1:0]       yaw;
    } chassis_cmd_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] rf;
        logic signed [OUT_W-1:0] lf;
        logic signed [OUT_W-1:0] lb;
        logic signed [OUT_W-1:0] rb;
    } wheel_set_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                    start = 1'b0;
    logic                    busy;
    logic signed [VX_W-1:0]  vx_cmd = '0;
    logic signed [VY_W-1:0]  vy_cmd = '0;
    logic signed [WZ_W-1:0]  wz_cmd = '0;
    logic [ANG_W-1:0]        yaw_offset = '0;
    logic                    done;
    logic signed [OUT_W-1:0] right_front_speed;
    logic signed [OUT_W-1:0] left_front_speed;
    logic signed [OUT_W-1:0] left_back_speed;
    logic signed [OUT_W-1:0] right_back_speed;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [ADDR_W-1:0]       paddr = '0;
    logic [DATA_W-1:0]       pwdata = '0;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;

    // predictor copy of the registers
    logic [ARM_W-1:0] front_arm_q = FRONT_ARM_RST;
    logic [ARM_W-1:0] back_arm_q = BACK_ARM_RST;
    logic [INV_W-1:0] inv_radius_q = INV_RADIUS_RST;

    longint sine_q15 [SINE_TABLE_SIZE];

    chassis_cmd_t cmd_pending [$];
    wheel_set_t   speeds_due [$];

    int unsigned idle_pct = 10;
    int unsigned n_loaded = 0;
    int unsigned n_checked = 0;
    int unsigned n_bad = 0;
    int unsigned n_cycles = 0;
    bit          taken = 1'b0;
    bit          hold = 1'b0;

    chassis_cmd_t next_cmd;
    chassis_cmd_t seen_cmd;
    wheel_set_t   want;
    wheel_set_t   got;

    mecanum_field_oriented_wheel_speeds u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .vx_cmd            (vx_cmd),
        .vy_cmd            (vy_cmd),
        .wz_cmd            (wz_cmd),
        .yaw_offset        (yaw_offset),
        .done              (done),
        .right_front_speed (right_front_speed),
        .left_front_speed  (left_front_speed),
        .left_back_speed   (left_back_speed),
        .right_back_speed  (right_back_speed),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #5 clk = ~clk;

    // Q30 series for sin, folded into +-pi/2, rounded to Q15
    function automatic longint sine_point(input longint k);
        longint x;
        longint half_pi;
        longint x2;
        longint term;
        longint acc;
        longint r;
        x = (2 * PI_Q30 * k) / SINE_TABLE_SIZE;
        half_pi = PI_Q30 / 2;
        if (x > PI_Q30)
            x = x - 2 * PI_Q30;
        if (x > half_pi)
            x = PI_Q30 - x;
        else if (x < -half_pi)
            x = -PI_Q30 - x;
        x2 = (x * x) / (64'sd1 <<< 30);
        term = x;
        acc = x;
        for (int n = 1; n <= 10; n++)
        begin
            term = -((term * x2) / (64'sd1 <<< 30)) / longint'((2 * n) * (2 * n + 1));
            acc = acc + term;
        end
        r = (acc + ((acc >= 0) ? 64'sd16384 : -64'sd16384)) / 64'sd32768;
        if (r > 64'sd32767)
            r = 64'sd32767;
        if (r < -64'sd32767)
            r = -64'sd32767;
        return r;
    endfunction

    function automatic longint lerp_sine(input logic [ANG_W-1:0] ang);
        logic [31:0] pos;
        int unsigned idx;
        int unsigned nx;
        longint a;
        longint b;
        longint frac;
        pos = 32'(ang) * 32'(SINE_TABLE_SIZE);
        idx = pos >> 16;
        if (idx >= SINE_TABLE_SIZE)
            idx = 0;
        nx = (idx + 1) % SINE_TABLE_SIZE;
        a = sine_q15[idx];
        b = sine_q15[nx];
        frac = longint'(pos[15:0]);
        return a + (((b - a) * frac + 64'sd32768) >>> 16);
    endfunction

    function automatic logic signed [OUT_W-1:0] wheel_speed(input longint term,
                                                            input longint arm,
                                                            input longint wz,
                                                            input longint inv);
        longint acc;
        longint r;
        acc = 1000 * term + arm * wz * 64'sd32768;
        r = (acc * inv + (64'sd1 <<< 30)) >>> 31;
        if (r > 64'sd8388607)
            r = 64'sd8388607;
        if (r < -64'sd8388608)
            r = -64'sd8388608;
        return r[OUT_W-1:0];
    endfunction

    function automatic wheel_set_t predict_wheels(input chassis_cmd_t c);
        longint vx;
        longint vy;
        longint wz;
        longint s;
        longint co;
        longint vxr;
        longint vyr;
        logic [ANG_W-1:0] yaw_c;
        wheel_set_t w;
        vx = longint'(c.vx);
        vy = longint'(c.vy);
        wz = longint'(c.wz);
        yaw_c = c.yaw + QUARTER_TURN;
        s = lerp_sine(c.yaw);
        co = lerp_sine(yaw_c);
        vxr = vx * co - vy * s;
        vyr = vy * co + vx * s;
        w.rf = wheel_speed(-vxr - vyr, longint'(front_arm_q), wz, longint'(inv_radius_q));
        w.lf = wheel_speed(vxr - vyr, longint'(front_arm_q), wz, longint'(inv_radius_q));
        w.lb = wheel_speed(vxr + vyr, longint'(back_arm_q), wz, longint'(inv_radius_q));
        w.rb = wheel_speed(-vxr + vyr, longint'(back_arm_q), wz, longint'(inv_radius_q));
        return w;
    endfunction

    function automatic chassis_cmd_t rand_cmd();
        chassis_cmd_t c;
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
        begin
            c.vx = VX_W'($urandom);
            c.vy = VY_W'($urandom);
            c.wz = WZ_W'($urandom);
        end
        else if (sel < 80)
        begin
            c.vx = VX_W'(int'($urandom_range(0, 16000)) - 8000);
            c.vy = VY_W'(int'($urandom_range(0, 16000)) - 8000);
            c.wz = WZ_W'(int'($urandom_range(0, 40000)) - 20000);
        end
        else
        begin
            // corner values, mixed per field
            case ($urandom_range(0, 3))
                0: c.vx = {1'b0, {(VX_W-1){1'b1}}};
                1: c.vx = {1'b1, {(VX_W-1){1'b0}}};
                2: c.vx = '0;
                default: c.vx = '1;
            endcase
            case ($urandom_range(0, 3))
                0: c.vy = {1'b0, {(VY_W-1){1'b1}}};
                1: c.vy = {1'b1, {(VY_W-1){1'b0}}};
                2: c.vy = '0;
                default: c.vy = VY_W'(1);
            endcase
            case ($urandom_range(0, 3))
                0: c.wz = {1'b0, {(WZ_W-1){1'b1}}};
                1: c.wz = {1'b1, {(WZ_W-1){1'b0}}};
                2: c.wz = '0;
                default: c.wz = '1;
            endcase
        end
        case ($urandom_range(0, 3))
            0: c.yaw = ANG_W'($urandom_range(0, SINE_TABLE_SIZE - 1) * (65536 / SINE_TABLE_SIZE));
            1: c.yaw = ANG_W'($urandom_range(0, 3) * 16384 + $urandom_range(0, 3)
                              - $urandom_range(0, 3));
            default: c.yaw = ANG_W'($urandom);
        endcase
        return c;
    endfunction

    task automatic add_cmd(input int vx, input int vy, input int wz, input int yaw);
        chassis_cmd_t c;
        c.vx = VX_W'(vx);
        c.vy = VY_W'(vy);
        c.wz = WZ_W'(wz);
        c.yaw = ANG_W'(yaw);
        cmd_pending.push_back(c);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (cmd_pending.size() != 0 || n_checked != n_loaded);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = ADDR_W'(4 * int'(idx));
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_FRONT_ARM:  front_arm_q = val[ARM_W-1:0];
            REG_BACK_ARM:   back_arm_q = val[ARM_W-1:0];
            REG_INV_RADIUS: inv_radius_q = val[INV_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_cfg(input int front, input int back, input int inv);
        apb_write(REG_FRONT_ARM, DATA_W'(front));
        apb_write(REG_BACK_ARM, DATA_W'(back));
        apb_write(REG_INV_RADIUS, DATA_W'(inv));
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++)
            cmd_pending.push_back(rand_cmd());
        wait_drained();
    endtask

    // sender: holds an item until it is taken, then loads the next or idles
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!start || taken)
            begin
                taken = 1'b0;
                if (hold && n_checked == n_loaded)
                    hold = 1'b0;
                if (!hold && cmd_pending.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    next_cmd = cmd_pending.pop_front();
                    start <= 1'b1;
                    vx_cmd <= next_cmd.vx;
                    vy_cmd <= next_cmd.vy;
                    wz_cmd <= next_cmd.wz;
                    yaw_offset <= next_cmd.yaw;
                    n_loaded++;
                    // now and then wait for the pipeline to empty
                    if (n_loaded % 150 == 0)
                        hold = 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                    vx_cmd <= VX_W'($urandom);
                    vy_cmd <= VY_W'($urandom);
                    wz_cmd <= WZ_W'($urandom);
                    yaw_offset <= ANG_W'($urandom);
                end
            end
        end
    end

    // acceptance and result check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                taken = 1'b1;
                seen_cmd.vx = vx_cmd;
                seen_cmd.vy = vy_cmd;
                seen_cmd.wz = wz_cmd;
                seen_cmd.yaw = yaw_offset;
                speeds_due.push_back(predict_wheels(seen_cmd));
            end
            if (done)
            begin
                got.rf = right_front_speed;
                got.lf = left_front_speed;
                got.lb = left_back_speed;
                got.rb = right_back_speed;
                if (speeds_due.size() == 0)
                begin
                    if (n_bad < REPORT_MAX)
                        $display("unexpected result: rf=%0d lf=%0d lb=%0d rb=%0d",
                                 got.rf, got.lf, got.lb, got.rb);
                    n_bad++;
                end
                else
                begin
                    want = speeds_due.pop_front();
                    n_checked++;
                    if (got.rf !== want.rf || got.lf !== want.lf
                        || got.lb !== want.lb || got.rb !== want.rb)
                    begin
                        if (n_bad < REPORT_MAX)
                            $display("mismatch: exp rf=%0d lf=%0d lb=%0d rb=%0d, got rf=%0d lf=%0d lb=%0d rb=%0d",
                                     want.rf, want.lf, want.lb, want.rb,
                                     got.rf, got.lf, got.lb, got.rb);
                        n_bad++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        for (int k = 0; k < SINE_TABLE_SIZE; k++)
            sine_q15[k] = sine_point(longint'(k));
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset register values
        idle_pct = 10;
        add_cmd(0, 0, 0, 0);
        add_cmd(8191, 0, 0, 0);
        add_cmd(-8192, 0, 0, 0);
        add_cmd(0, 8191, 0, 16384);
        add_cmd(0, -8192, 0, 32768);
        add_cmd(0, 0, 32767, 0);
        add_cmd(0, 0, -32768, 49152);
        add_cmd(8000, -8000, 20000, 65535);
        add_cmd(-8000, 8000, -20000, 1);
        add_cmd(1000, 2000, 300, 8192);
        add_cmd(8191, 8191, 32767, 100);
        add_cmd(-8192, -8192, -32768, 65408);   // last entry, wraps to the first
        add_cmd(1, -1, -1, 12345);
        wait_drained();

        // widest arms and radius: saturation both ways
        set_cfg(2047, 2047, 8191);
        add_cmd(8191, 8191, 32767, 0);
        add_cmd(-8192, -8192, -32768, 0);
        add_cmd(8191, -8192, 32767, 24576);
        add_cmd(-8192, 8191, -32768, 57344);
        wait_drained();

        // zero reciprocal radius: all speeds zero
        set_cfg(2047, 2047, 0);
        add_cmd(8191, 8191, 32767, 777);
        add_cmd(-8192, -8192, -32768, 40000);
        cmd_pending.push_back(rand_cmd());
        wait_drained();

        set_cfg(0, 2000, 131);
        idle_pct = 10;
        run_random(270);

        set_cfg(2000, 0, 6554);
        idle_pct = 49;
        run_random(270);

        idle_pct = 0;
        set_cfg($urandom_range(0, 2047), $urandom_range(0, 2047), $urandom_range(0, 8191));
        run_random(130);
        set_cfg($urandom_range(0, 2047), $urandom_range(0, 2047), $urandom_range(1, 8191));
        run_random(130);

        repeat (LATENCY + 4) @(negedge clk);
        n_bad += speeds_due.size();
        if (n_bad == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/mfows_pkg.sv
design/mfows_cfg.sv
design/mfows_sincos.sv
design/mfows_rotate.sv
design/mfows_wheel.sv
design/mecanum_field_oriented_wheel_speeds.sv
tb/sv/mecanum_field_oriented_wheel_speeds_tb.sv
